FILE: rtl/lcdcon_pkg.sv
// Package for the two-line LCD text console.
// Holds the line geometry, the controller command codes and the character codes.
// No dependencies.
package lcdcon_pkg;

    // Line geometry. Line 0 keeps its last cell for a spinner.
    localparam int LINE_LENGTH = 16;
    localparam int COL_W       = $clog2(LINE_LENGTH);
    localparam int IDX_W       = $clog2(LINE_LENGTH + 1);

    // Controller commands.
    localparam logic [7:0] CMD_SET_ADDR = 8'h80;
    localparam logic [7:0] LINE1_OFFSET = 8'h40;
    localparam logic [7:0] CMD_LINE0    = CMD_SET_ADDR;
    localparam logic [7:0] CMD_LINE1    = CMD_SET_ADDR | LINE1_OFFSET;

    // Character codes.
    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] CHAR_LF    = 8'd10;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_NUL   = 8'h00;

    // Configuration register map.
    localparam int PADDR_W = 2;
    localparam int PDATA_W = 32;

endpackage

FILE: rtl/two_line_lcd_text_console.sv
// Two-line LCD text console: line store, cursor and the line-feed write sequencer.
// Depends on lcdcon_pkg.
//
//   channel   | direction | payload                         | handshake
//   ----------+-----------+---------------------------------+-----------------
//   s_        | in        | s_char_code[7:0]                | s_valid/s_ready
//   m_        | out       | m_is_data, m_write_byte, m_last | m_valid/m_ready
//   APB       | in        | paddr, pwdata, prdata           | psel/penable
//
// An ordinary character or carriage return is taken in S_IDLE. A line feed sends up to
// 2*LINE_LENGTH+1 controller writes, paced by the single store read port that the
// sequencer walks one byte per cycle while m_ready does not stall it.
// Reset fills the line store with spaces at once and clears cursor, line and enable.
// A stalled m_ready holds the sequencer; s_ready is high only while the sequencer is idle.
module two_line_lcd_text_console (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [7:0]                        s_char_code,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_is_data,
    output logic [7:0]                        m_write_byte,
    output logic                              m_last,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lcdcon_pkg::PADDR_W-1:0]    paddr,
    input  logic [lcdcon_pkg::PDATA_W-1:0]    pwdata,
    output logic [lcdcon_pkg::PDATA_W-1:0]    prdata,
    output logic                              pready
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMD,
        S_DATA,
        S_FIN
    } state_t;

    typedef logic [7:0] line_t [lcdcon_pkg::LINE_LENGTH];

    state_t                        state_reg, state_next;
    line_t                         store_reg  [2];
    line_t                         store_next [2];
    logic                          cur_line_reg, cur_line_next;
    logic [lcdcon_pkg::IDX_W-1:0]  cursor_reg, cursor_next;
    logic                          enable_reg, enable_next;
    logic                          phase_reg, phase_next;
    logic [lcdcon_pkg::IDX_W-1:0]  idx_reg, idx_next;
    logic [7:0]                    byte_reg, byte_next;
    logic                          m_valid_reg, m_valid_next;
    logic                          m_is_data_reg, m_is_data_next;
    logic [7:0]                    m_byte_reg, m_byte_next;
    logic                          m_last_reg, m_last_next;

    logic                          slot_free;
    logic                          rd_line;
    logic [lcdcon_pkg::IDX_W-1:0]  rd_idx;
    logic [lcdcon_pkg::IDX_W-1:0]  run_len;
    logic [7:0]                    rd_byte;
    logic                          rd_end;
    logic [lcdcon_pkg::IDX_W-1:0]  cur_cap;
    logic [lcdcon_pkg::IDX_W-1:0]  new_cap;
    logic                          new_line;

    // Handshake outputs.
    assign s_ready      = (state_reg == S_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_is_data    = m_is_data_reg;
    assign m_write_byte = m_byte_reg;
    assign m_last       = m_last_reg;
    assign slot_free    = !m_valid_reg || m_ready;

    // Configuration port: a single register, always ready.
    assign pready = 1'b1;
    assign prdata = {{(lcdcon_pkg::PDATA_W-1){1'b0}}, enable_reg};

    // Store read port: the other line in phase 0, the current line in phase 1.
    assign rd_line = cur_line_reg ^ ~phase_reg;
    assign run_len = phase_reg ? lcdcon_pkg::IDX_W'(lcdcon_pkg::LINE_LENGTH)
                               : lcdcon_pkg::IDX_W'(lcdcon_pkg::LINE_LENGTH - 1);
    assign rd_idx  = (state_reg == S_DATA) ? idx_reg + 1'b1 : '0;

    always_comb begin
        if (rd_idx < run_len) begin
            rd_byte = store_reg[rd_line][rd_idx[lcdcon_pkg::COL_W-1:0]];
        end else begin
            rd_byte = lcdcon_pkg::CHAR_NUL;
        end
    end

    assign rd_end = (rd_byte == lcdcon_pkg::CHAR_NUL);

    // Line capacities for character writes and for the clear after a line feed.
    assign cur_cap  = cur_line_reg ? lcdcon_pkg::IDX_W'(lcdcon_pkg::LINE_LENGTH)
                                   : lcdcon_pkg::IDX_W'(lcdcon_pkg::LINE_LENGTH - 1);
    assign new_line = ~cur_line_reg;
    assign new_cap  = new_line ? lcdcon_pkg::IDX_W'(lcdcon_pkg::LINE_LENGTH)
                               : lcdcon_pkg::IDX_W'(lcdcon_pkg::LINE_LENGTH - 1);

    // Next-state logic of the sequencer, the store and the output register.
    always_comb begin
        state_next     = state_reg;
        store_next     = store_reg;
        cur_line_next  = cur_line_reg;
        cursor_next    = cursor_reg;
        enable_next    = enable_reg;
        phase_next     = phase_reg;
        idx_next       = idx_reg;
        byte_next      = byte_reg;
        m_valid_next   = m_valid_reg;
        m_is_data_next = m_is_data_reg;
        m_byte_next    = m_byte_reg;
        m_last_next    = m_last_reg;

        // The output register empties when its request is taken.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (psel && penable && pwrite) begin
            enable_next = pwdata[0];
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    if (s_char_code == lcdcon_pkg::CHAR_LF) begin
                        phase_next = 1'b0;
                        state_next = enable_reg ? S_CMD : S_FIN;
                    end else if (s_char_code != lcdcon_pkg::CHAR_CR) begin
                        // Store the character while the line has room.
                        if (cursor_reg < cur_cap) begin
                            store_next[cur_line_reg][cursor_reg[lcdcon_pkg::COL_W-1:0]] =
                                s_char_code;
                            cursor_next = cursor_reg + 1'b1;
                        end
                    end
                end
            end

            S_CMD: begin
                // Set-address command; the first byte of the run is read alongside.
                if (slot_free) begin
                    m_valid_next   = 1'b1;
                    m_is_data_next = 1'b0;
                    m_byte_next    = phase_reg ? lcdcon_pkg::CMD_LINE1 : lcdcon_pkg::CMD_LINE0;
                    m_last_next    = phase_reg && rd_end;
                    idx_next       = '0;
                    byte_next      = rd_byte;
                    if (!rd_end) begin
                        state_next = S_DATA;
                    end else if (phase_reg) begin
                        state_next = S_FIN;
                    end else begin
                        phase_next = 1'b1;
                    end
                end
            end

            S_DATA: begin
                // Send the held byte and look one byte ahead to spot the run's end.
                if (slot_free) begin
                    m_valid_next   = 1'b1;
                    m_is_data_next = 1'b1;
                    m_byte_next    = byte_reg;
                    m_last_next    = phase_reg && rd_end;
                    idx_next       = rd_idx;
                    byte_next      = rd_byte;
                    if (!rd_end) begin
                        state_next = S_DATA;
                    end else if (phase_reg) begin
                        state_next = S_FIN;
                    end else begin
                        phase_next = 1'b1;
                        state_next = S_CMD;
                    end
                end
            end

            S_FIN: begin
                // Swap lines, blank the new current line and home the cursor.
                for (int c = 0; c < lcdcon_pkg::LINE_LENGTH; c++) begin
                    if (lcdcon_pkg::IDX_W'(c) < new_cap) begin
                        store_next[new_line][lcdcon_pkg::COL_W'(c)] = lcdcon_pkg::CHAR_SPACE;
                    end
                end
                cur_line_next = new_line;
                cursor_next   = '0;
                state_next    = S_IDLE;
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, store and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            cur_line_reg <= 1'b0;
            cursor_reg   <= '0;
            enable_reg   <= 1'b0;
            phase_reg    <= 1'b0;
            idx_reg      <= '0;
            m_valid_reg  <= 1'b0;
            for (int l = 0; l < 2; l++) begin
                for (int c = 0; c < lcdcon_pkg::LINE_LENGTH; c++) begin
                    store_reg[1'(l)][lcdcon_pkg::COL_W'(c)] <= lcdcon_pkg::CHAR_SPACE;
                end
            end
        end else begin
            state_reg    <= state_next;
            cur_line_reg <= cur_line_next;
            cursor_reg   <= cursor_next;
            enable_reg   <= enable_next;
            phase_reg    <= phase_next;
            idx_reg      <= idx_next;
            m_valid_reg  <= m_valid_next;
            store_reg    <= store_next;
        end
        byte_reg      <= byte_next;
        m_is_data_reg <= m_is_data_next;
        m_byte_reg    <= m_byte_next;
        m_last_reg    <= m_last_next;
    end

    // A data request never carries the zero byte that ends a run.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_is_data) |-> (m_write_byte != lcdcon_pkg::CHAR_NUL))
        else $error("zero byte sent as data");

    // Command requests are only the two set-address codes.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_is_data) |->
            (m_write_byte == lcdcon_pkg::CMD_LINE0 || m_write_byte == lcdcon_pkg::CMD_LINE1))
        else $error("unexpected command byte");

    // The spinner cell of line 0 keeps its space.
    assert property (@(posedge aclk) disable iff (!aresetn)
        store_reg[0][lcdcon_pkg::LINE_LENGTH-1] == lcdcon_pkg::CHAR_SPACE)
        else $error("spinner cell overwritten");

    // The cursor never passes the capacity of the current line.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cursor_reg <= cur_cap)
        else $error("cursor beyond line capacity");

    // Finishing a line feed swaps the line and homes the cursor.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FIN) |=>
            (cursor_reg == '0 && cur_line_reg != $past(cur_line_reg) && state_reg == S_IDLE))
        else $error("line feed did not advance the console");

endmodule

FILE: tb/console_mirror_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the two-line LCD text console testbench: a mirror of the line store,
// the cursor and the enable bit, plus the queue of controller writes still to come.
// Depends on lcdcon_pkg for the line geometry and the command and character codes.
package console_mirror_pkg;

    // One write to the LCD controller as seen on the result channel.
    typedef struct packed {
        logic       is_data;
        logic [7:0] wbyte;
        logic       last;
    } lcd_write_t;

    class console_mirror;
        logic [7:0]  text [2][lcdcon_pkg::LINE_LENGTH];
        bit          cur_line;
        int unsigned cursor;
        bit          enable;
        lcd_write_t  pending_writes [$];
        int          mismatches;
        int          writes_checked;
        int          line_feeds;
        int          drops;

        // State right after reset: both lines blank, display not ready.
        function new();
            foreach (text[l, i]) text[l][i] = lcdcon_pkg::CHAR_SPACE;
            cur_line       = 1'b0;
            cursor         = 0;
            enable         = 1'b0;
            mismatches     = 0;
            writes_checked = 0;
            line_feeds     = 0;
            drops          = 0;
        endfunction

        function void set_enable(bit value);
            enable = value;
        endfunction

        function int pending();
            return pending_writes.size();
        endfunction

        // Line 0 gives up its last cell to the spinner.
        function int unsigned capacity(bit line);
            return line ? lcdcon_pkg::LINE_LENGTH : lcdcon_pkg::LINE_LENGTH - 1;
        endfunction

        // Address command followed by the line's bytes, cut short at the first zero byte.
        function void queue_line(logic [7:0] cmd, bit line, int unsigned len);
            pending_writes.push_back('{1'b0, cmd, 1'b0});
            for (int unsigned i = 0; i < len; i++) begin
                if (text[line][i] == lcdcon_pkg::CHAR_NUL) break;
                pending_writes.push_back('{1'b1, text[line][i], 1'b0});
            end
        endfunction

        // Apply one accepted character request and queue the writes it causes.
        function void take_char(logic [7:0] c);
            if (c == lcdcon_pkg::CHAR_CR) return;
            if (c == lcdcon_pkg::CHAR_LF) begin
                line_feeds++;
                if (enable) begin
                    queue_line(lcdcon_pkg::CMD_LINE0, ~cur_line, capacity(1'b0));
                    queue_line(lcdcon_pkg::CMD_LINE1, cur_line, capacity(1'b1));
                    pending_writes[pending_writes.size() - 1].last = 1'b1;
                end
                cur_line = ~cur_line;
                for (int unsigned i = 0; i < capacity(cur_line); i++)
                    text[cur_line][i] = lcdcon_pkg::CHAR_SPACE;
                cursor = 0;
                return;
            end
            if (cursor < capacity(cur_line)) begin
                text[cur_line][cursor] = c;
                cursor++;
            end else begin
                drops++;
            end
        endfunction

        // Compare one controller write against the oldest one still expected.
        function void check_write(logic is_data, logic [7:0] wbyte, logic last);
            lcd_write_t exp_w;
            if (pending_writes.size() == 0) begin
                $error("unexpected controller write: is_data=%0d write_byte=%02h last=%0d",
                       is_data, wbyte, last);
                mismatches++;
                return;
            end
            exp_w = pending_writes.pop_front();
            writes_checked++;
            if (is_data !== exp_w.is_data) begin
                $error("is_data: expected %0d, got %0d", exp_w.is_data, is_data);
                mismatches++;
            end
            if (wbyte !== exp_w.wbyte) begin
                $error("write_byte: expected %02h, got %02h", exp_w.wbyte, wbyte);
                mismatches++;
            end
            if (last !== exp_w.last) begin
                $error("last: expected %0d, got %0d", exp_w.last, last);
                mismatches++;
            end
        endfunction
    endclass

endpackage

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Top-level testbench for two_line_lcd_text_console: drives characters, the APB enable
// register and result back-pressure, and checks every controller write in order.
// Depends on lcdcon_pkg, console_mirror_pkg and the RTL of the console.
module tb_top;

    localparam logic [lcdcon_pkg::PADDR_W-1:0] REG_DISPLAY_ENABLE = '0;
    localparam int SETTLE_CYCLES   = 2 * lcdcon_pkg::LINE_LENGTH + 8;
    localparam int PHASE_CHARS     = 46;
    localparam int HOLD_CYCLES     = 400;
    localparam int CYCLE_LIMIT     = 400000;

    logic                            aclk;
    logic                            aresetn;
    logic                            s_valid;
    logic                            s_ready;
    logic [7:0]                      s_char_code;
    logic                            m_valid;
    logic                            m_ready;
    logic                            m_is_data;
    logic [7:0]                      m_write_byte;
    logic                            m_last;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [lcdcon_pkg::PADDR_W-1:0]  paddr;
    logic [lcdcon_pkg::PDATA_W-1:0]  pwdata;
    logic [lcdcon_pkg::PDATA_W-1:0]  prdata;
    logic                            pready;

    console_mirror_pkg::console_mirror sb;
    int            sender_idle_pct;
    int            recv_stall_pct;
    int            holds_asked;
    int            chars_sent;
    int            cycle_count;

    two_line_lcd_text_console u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_char_code  (s_char_code),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_is_data    (m_is_data),
        .m_write_byte (m_write_byte),
        .m_last       (m_last),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // 100 MHz clock.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Run guard.
    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off whenever one is asked for.
    initial begin : receiver
        int holds_served;
        holds_served = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (holds_asked > holds_served) begin
                holds_served++;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // Result monitor.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_write(m_is_data, m_write_byte, m_last);
    end

    // Offer one character request and hold it until the console takes it.
    task automatic send_char(input logic [7:0] c);
        @(negedge aclk);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_char_code <= c;
        do @(posedge aclk); while (!s_ready);
        sb.take_char(c);
        if (c != lcdcon_pkg::CHAR_CR) chars_sent++;
    endtask

    // Drop the request line and wait until the console has nothing left to emit.
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // APB write of the enable bit, then a read-back of the same register.
    task automatic set_display_enable(input bit value);
        settle();
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_DISPLAY_ENABLE;
        pwdata  <= lcdcon_pkg::PDATA_W'(value);
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.set_enable(value);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        psel    <= 1'b1;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata[0] !== value) begin
            $error("display_enable: expected %0d, got %0d", value, prdata[0]);
            sb.mismatches++;
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // One console line with random content. Most end in a line feed; some run on
    // past the line's end, and a few carry zero bytes or carriage returns.
    task automatic send_random_line();
        int         len;
        int         r;
        logic [7:0] c;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 22) : $urandom_range(0, 16);
        for (int i = 0; i < len; i++) begin
            r = $urandom_range(0, 99);
            if (r < 3) c = lcdcon_pkg::CHAR_NUL;
            else if (r < 6) c = lcdcon_pkg::CHAR_CR;
            else begin
                c = 8'($urandom_range(0, 255));
                if (c == lcdcon_pkg::CHAR_LF) c = lcdcon_pkg::CHAR_SPACE;
            end
            send_char(c);
        end
        if ($urandom_range(0, 19) != 0) send_char(lcdcon_pkg::CHAR_LF);
    endtask

    initial begin : stimulus
        bit phase_enable [5];
        int phase_start;
        phase_enable = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
        sb              = new();
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        holds_asked     = 0;
        chars_sent      = 0;
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_char_code     = '0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Display not ready: the line feed only advances the console.
        send_char("H");
        send_char(lcdcon_pkg::CHAR_LF);

        // Extreme bytes, a zero byte that cuts the line short, and an ignored return.
        set_display_enable(1'b1);
        send_char(8'hFF);
        send_char(lcdcon_pkg::CHAR_NUL);
        send_char(lcdcon_pkg::CHAR_CR);
        send_char("z");
        send_char(lcdcon_pkg::CHAR_LF);

        // Overfill line 0: the sixteenth character would land on the spinner cell and is dropped.
        for (int i = 0; i < lcdcon_pkg::LINE_LENGTH; i++) send_char(8'("a" + i));
        send_char(lcdcon_pkg::CHAR_LF);

        // Random phases with different pacing; the last one adds a long receiver hold-off.
        for (int p = 0; p < 5; p++) begin
            set_display_enable(phase_enable[p]);
            case (p)
                1: begin sender_idle_pct = 69; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 69; end
                3: begin sender_idle_pct = 13; recv_stall_pct = 13; end
                default: begin sender_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            if (p == 4) holds_asked++;
            phase_start = chars_sent;
            while (chars_sent - phase_start < PHASE_CHARS) send_random_line();
        end

        settle();
        $display("tb_top: %0d characters over five pacing phases, %0d line feeds, %0d dropped",
                 chars_sent, sb.line_feeds, sb.drops);
        $display("tb_top: %0d controller writes compared, display enable set to 0 and 1",
                 sb.writes_checked);
        if (sb.mismatches == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
